/* hdl/radix_text_to_unsigned_macros.svh */
// Assertion macros for the text-to-unsigned converter.
`ifndef RADIX_TEXT_TO_UNSIGNED_MACROS_SVH
`define RADIX_TEXT_TO_UNSIGNED_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge out of reset.
`define RTU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rtu assertion failed");
// Next-cycle implication.
`define RTU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rtu assertion failed");
`else
`define RTU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define RTU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hdl/rtu_pkg.sv */
// Shared widths, codes and character helpers for the text-to-unsigned converter.
package rtu_pkg;

  // Fixed field widths
  localparam int unsigned ChW     = 8;
  localparam int unsigned RadixW  = 6;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 16;

  // Accumulator width range and default
  localparam int unsigned DefaultWidth = 32;
  localparam int unsigned MaxWidth     = 64;

  // Radix handling
  localparam logic [RadixW-1:0] RadixReset = RadixW'(10);
  localparam logic [RadixW-1:0] RadixTen   = RadixW'(10);
  localparam logic [RadixW-1:0] RadixOne   = RadixW'(1);
  localparam logic [RadixW-1:0] RadixMax   = RadixW'(36);

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    StOk       = 2'd0,
    StBadRadix = 2'd1,
    StRange    = 2'd2
  } status_e;

  // Character codes
  localparam logic [ChW-1:0] ChNul   = 8'd0;
  localparam logic [ChW-1:0] ChTab   = 8'd9;
  localparam logic [ChW-1:0] ChLf    = 8'd10;
  localparam logic [ChW-1:0] ChVt    = 8'd11;
  localparam logic [ChW-1:0] ChFf    = 8'd12;
  localparam logic [ChW-1:0] ChCr    = 8'd13;
  localparam logic [ChW-1:0] ChPlus  = 8'd43;
  localparam logic [ChW-1:0] ChZero  = 8'd48;
  localparam logic [ChW-1:0] ChNine  = 8'd57;
  localparam logic [ChW-1:0] ChUpA   = 8'd65;
  localparam logic [ChW-1:0] ChUpZ   = 8'd90;
  localparam logic [ChW-1:0] ChLoA   = 8'd97;
  localparam logic [ChW-1:0] ChLoZ   = 8'd122;
  localparam logic [ChW-1:0] NoDigit = 8'd255;

  // Whitespace skipped before the number: tab, LF, VT, FF and CR, but not space
  function automatic logic is_space(input logic [ChW-1:0] c);
    return (c == ChFf) || (c == ChLf) || (c == ChCr) || (c == ChTab) || (c == ChVt);
  endfunction

  // Digit value of a character, NoDigit if it is none
  function automatic logic [ChW-1:0] digit_of(input logic [ChW-1:0] c);
    logic [ChW-1:0] d;
    d = NoDigit;
    if (c >= ChZero && c <= ChNine) begin
      d = c - ChZero;
    end else if (c >= ChUpA && c <= ChUpZ) begin
      d = c - ChUpA + 8'd10;
    end else if (c >= ChLoA && c <= ChLoZ) begin
      d = c - ChLoA + 8'd10;
    end
    return d;
  endfunction

endpackage

/* hdl/rtu_if.sv */
// Valid/ready channel interfaces for characters, results and the radix register.
interface rtu_in_if;
  logic                      valid;
  logic                      ready;
  logic [rtu_pkg::ChW-1:0]   ch;
  logic                      start_req;

  modport source (output valid, output ch, output start_req, input ready);
  modport sink   (input valid, input ch, input start_req, output ready);
endinterface

interface rtu_out_if;
  logic                         valid;
  logic                         ready;
  logic [rtu_pkg::ValueW-1:0]   value;
  logic [rtu_pkg::StatusW-1:0]  status;
  logic [rtu_pkg::CountW-1:0]   consumed;

  modport source (output valid, output value, output status, output consumed,
                  input ready);
  modport sink   (input valid, input value, input status, input consumed,
                  output ready);
endinterface

interface rtu_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rtu_pkg::RadixW-1:0]   radix;

  modport source (output valid, output radix, input ready);
  modport sink   (input valid, input radix, output ready);
endinterface

/* hdl/radix_text_to_unsigned.sv */
// Top level: streaming text-to-unsigned converter, one character per cycle.
//
//  channel | dir | fields                    | transfer when
//  in_i    | in  | ch, start_req             | in_i.valid && in_i.ready
//  res_o   | out | value, status, consumed   | res_o.valid && res_o.ready
//  cfg_i   | in  | radix                     | cfg_i.valid && cfg_i.ready
//
// One character per cycle unless the result register stalls.
// The multiply-add of accumulator by base plus digit sits between the character
// register and the result register. Reset clears state, sets radix and base to ten.
// A stalled result holds the character register; the input takes a new character
// whenever the character register is empty or moves on. cfg_i is always ready.

`include "radix_text_to_unsigned_macros.svh"

module radix_text_to_unsigned #(
  parameter int unsigned WIDTH = rtu_pkg::DefaultWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rtu_in_if.sink      in_i,
  rtu_out_if.source   res_o,
  rtu_cfg_if.sink     cfg_i
);

  localparam int unsigned ProdW = WIDTH + rtu_pkg::RadixW;

  typedef enum logic [2:0] {
    PhDone   = 3'b001,
    PhSkip   = 3'b010,
    PhDigits = 3'b100
  } phase_e;

  // Character register
  logic                          s1_valid_q;
  logic [rtu_pkg::ChW-1:0]       s1_ch_q;
  logic                          s1_start_q;

  // Parse state
  phase_e                        phase_q, phase_d, phase_eff;
  logic [WIDTH-1:0]              acc_q, acc_d, acc_eff;
  logic [rtu_pkg::CountW-1:0]    cnt_q, cnt_d, cnt_eff, cnt_inc;
  logic [rtu_pkg::RadixW-1:0]    base_q, base_d, base_eff;
  logic [rtu_pkg::RadixW-1:0]    radix_q;

  // Result register
  logic                          res_valid_q;
  logic [rtu_pkg::ValueW-1:0]    res_value_q, res_value_d;
  rtu_pkg::status_e              res_status_q, res_status_d;
  logic [rtu_pkg::CountW-1:0]    res_cnt_q, res_cnt_d;

  logic                          out_free, adv, emit, digit_step, radix_bad, ovf;
  logic [rtu_pkg::ChW-1:0]       digit;
  logic [ProdW-1:0]              sum;
  logic [rtu_pkg::MaxWidth-1:0]  acc_wide, lim_wide;
  logic [WIDTH-1:0]              lim;

  // Handshake: the character register moves on when the result register is free
  assign out_free    = !res_valid_q || res_o.ready;
  assign adv         = s1_valid_q && out_free;
  assign in_i.ready  = !s1_valid_q || out_free;
  assign cfg_i.ready = 1'b1;

  assign res_o.valid    = res_valid_q;
  assign res_o.value    = res_value_q;
  assign res_o.status   = res_status_q;
  assign res_o.consumed = res_cnt_q;

  // Step the parser for the held character
  always_comb begin
    radix_bad = (radix_q == rtu_pkg::RadixOne) || (radix_q > rtu_pkg::RadixMax);
    phase_eff = s1_start_q ? PhSkip : phase_q;
    base_eff  = s1_start_q ? ((radix_q == '0) ? rtu_pkg::RadixTen : radix_q) : base_q;
    acc_eff   = s1_start_q ? '0 : acc_q;
    cnt_eff   = s1_start_q ? '0 : cnt_q;
    cnt_inc   = (cnt_eff == '1) ? cnt_eff : cnt_eff + 1'b1;
    digit     = rtu_pkg::digit_of(s1_ch_q);
    sum       = ProdW'(acc_eff) * ProdW'(base_eff) + ProdW'(digit[rtu_pkg::RadixW-1:0]);
    ovf       = |sum[ProdW-1:WIDTH];
    lim       = '1;
    acc_wide  = rtu_pkg::MaxWidth'(acc_eff);
    lim_wide  = rtu_pkg::MaxWidth'(lim);

    phase_d      = phase_eff;
    acc_d        = acc_eff;
    cnt_d        = cnt_eff;
    base_d       = base_eff;
    emit         = 1'b0;
    digit_step   = 1'b0;
    res_value_d  = '0;
    res_status_d = rtu_pkg::StOk;
    res_cnt_d    = '0;

    if (s1_start_q && radix_bad) begin
      base_d       = base_q;
      phase_d      = PhDone;
      emit         = 1'b1;
      res_status_d = rtu_pkg::StBadRadix;
    end else begin
      unique case (phase_eff)
        PhDone: begin
        end
        PhSkip: begin
          if (rtu_pkg::is_space(s1_ch_q)) begin
            cnt_d = cnt_inc;
          end else begin
            phase_d = PhDigits;
            if (s1_ch_q == rtu_pkg::ChPlus) begin
              cnt_d = cnt_inc;
            end else begin
              digit_step = 1'b1;
            end
          end
        end
        PhDigits: begin
          digit_step = 1'b1;
        end
        default: begin
          phase_d = PhDone;
        end
      endcase

      if (digit_step) begin
        priority if (s1_ch_q == rtu_pkg::ChNul || digit >= rtu_pkg::ChW'(base_eff)) begin
          phase_d      = PhDone;
          emit         = 1'b1;
          res_value_d  = acc_wide[rtu_pkg::ValueW-1:0];
          res_status_d = rtu_pkg::StOk;
          res_cnt_d    = cnt_eff;
        end else if (ovf) begin
          phase_d      = PhDone;
          emit         = 1'b1;
          res_value_d  = lim_wide[rtu_pkg::ValueW-1:0];
          res_status_d = rtu_pkg::StRange;
        end else begin
          acc_d = sum[WIDTH-1:0];
          cnt_d = cnt_inc;
        end
      end
    end
  end

  // Control and parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      phase_q     <= PhDone;
      acc_q       <= '0;
      cnt_q       <= '0;
      base_q      <= rtu_pkg::RadixReset;
      radix_q     <= rtu_pkg::RadixReset;
    end else begin
      if (cfg_i.valid) begin
        radix_q <= cfg_i.radix;
      end
      if (in_i.valid && in_i.ready) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        cnt_q   <= cnt_d;
        base_q  <= base_d;
      end
      if (adv && emit) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_ch_q    <= in_i.ch;
      s1_start_q <= in_i.start_req;
    end
    if (adv && emit) begin
      res_value_q  <= res_value_d;
      res_status_q <= res_status_d;
      res_cnt_q    <= res_cnt_d;
    end
  end

  // Checks
  `RTU_ASSERT_NEXT(a_done_after_emit, clk_i, rst_ni, adv && emit, phase_q == PhDone)
  `RTU_ASSERT_IMPLIES(a_err_no_count, clk_i, rst_ni,
    res_valid_q && res_status_q != rtu_pkg::StOk, res_cnt_q == '0)
  `RTU_ASSERT_NEXT(a_count_saturates, clk_i, rst_ni, cnt_q == '1,
    cnt_q == '1 || cnt_q == '0)

endmodule
